FILE: design/dcc_pkg.sv
package dcc_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_IN_CHANNELS  = 2'd0,
        REG_OUT_CHANNELS = 2'd1,
        REG_KERNEL_TAPS  = 2'd2,
        REG_DILATION     = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_START,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic clr_init;
        logic clr_step;
        logic o_init;
        logic o_start;
        logic mac_issue;
        logic out_load;
        logic ptr_adv;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic clr_done;
        logic frame_end;
        logic mac_last;
        logic busy;
        logic out_free;
        logic o_last;
    } sts_t;

endpackage

FILE: design/dcc_ram.sv
module dcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/dcc_ctrl.sv
module dcc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dcc_pkg::sts_t sts,
    output dcc_pkg::cmd_t cmd
);

    dcc_pkg::state_t state_reg;
    dcc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            dcc_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = dcc_pkg::ST_IDLE;
                end
            end
            dcc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = dcc_pkg::ST_EXEC;
                end
            end
            dcc_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (sts.op == dcc_pkg::OP_CLEAR)
                begin
                    cmd.clr_init = 1'b1;
                    state_next   = dcc_pkg::ST_CLEAR;
                end
                else if (sts.frame_end)
                begin
                    cmd.o_init = 1'b1;
                    state_next = dcc_pkg::ST_START;
                end
                else
                begin
                    state_next = dcc_pkg::ST_IDLE;
                end
            end
            dcc_pkg::ST_START:
            begin
                cmd.o_start = 1'b1;
                state_next  = dcc_pkg::ST_MAC;
            end
            dcc_pkg::ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (sts.mac_last)
                begin
                    state_next = dcc_pkg::ST_DRAIN;
                end
            end
            dcc_pkg::ST_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = dcc_pkg::ST_OUT;
                end
            end
            dcc_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.o_last)
                    begin
                        cmd.ptr_adv = 1'b1;
                        state_next  = dcc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = dcc_pkg::ST_START;
                    end
                end
            end
            default:
            begin
                state_next = dcc_pkg::ST_IDLE;
            end
        endcase
    end

    a_mac_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcc_pkg::ST_MAC && sts.mac_last) |=> state_reg == dcc_pkg::ST_DRAIN)
        else $error("mac loop did not end on last term");

    a_out_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded into full output register");

    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == dcc_pkg::ST_EXEC)
        else $error("accepted transaction not executed");

endmodule

FILE: design/dcc_dpath.sv
module dcc_dpath #(
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_TAPS   = 4,
    parameter int HIST_DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dcc_pkg::op_t       in_op,
    input  logic [3:0]         in_channel,
    input  logic [3:0]         out_channel,
    input  logic [1:0]         tap,
    input  logic signed [15:0] value,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    input  dcc_pkg::cmd_t      cmd,
    output dcc_pkg::sts_t      sts,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [3:0]         out_index,
    output logic signed [15:0] out_value,
    output logic               last
);

    localparam int HTOT  = MAX_IN_CH * HIST_DEPTH;
    localparam int WTOT  = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
    localparam int CLR_N = (HTOT > WTOT) ? HTOT : WTOT;
    localparam int HAW   = (HTOT > 1) ? $clog2(HTOT) : 1;
    localparam int WAW   = (WTOT > 1) ? $clog2(WTOT) : 1;
    localparam int CLRW  = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int PW    = $clog2(HIST_DEPTH + 1);
    localparam int PTW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CW    = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
    localparam int OCW   = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int TW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int OUT_HI = (MAX_OUT_CH < 16) ? MAX_OUT_CH : 16;
    localparam int ACC_W = 34 + $clog2(MAX_IN_CH * MAX_TAPS + 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    // config
    logic [4:0] in_ch_reg;
    logic [4:0] out_ch_reg;
    logic [2:0] taps_reg;
    logic [8:0] dil_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg  <= 5'd1;
            out_ch_reg <= 5'd1;
            taps_reg   <= 3'd1;
            dil_reg    <= 9'd1;
        end
        else if (cfg_we)
        begin
            unique case (dcc_pkg::reg_idx_t'(cfg_index))
                dcc_pkg::REG_IN_CHANNELS:  in_ch_reg  <= cfg_data[4:0];
                dcc_pkg::REG_OUT_CHANNELS: out_ch_reg <= cfg_data[4:0];
                dcc_pkg::REG_KERNEL_TAPS:  taps_reg   <= cfg_data[2:0];
                dcc_pkg::REG_DILATION:     dil_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [PW-1:0] lim_arr [8];
    for (genvar g = 0; g < 8; g++)
    begin : g_lim
        localparam int DEN = (g > 1) ? (g - 1) : 1;
        localparam int RAW = (g > 1) ? ((HIST_DEPTH - 1) / DEN) : HIST_DEPTH;
        localparam int LIM = (RAW < 1) ? 1 : RAW;
        assign lim_arr[g] = PW'(LIM);
    end

    logic [6:0]    nin;
    logic [4:0]    nout;
    logic [2:0]    ntaps;
    logic [8:0]    dil_c;
    logic [8:0]    dil;
    logic [PW-1:0] lim;
    logic [15:0]   span_raw;
    logic [PW-1:0] span;

    always_comb
    begin
        if (in_ch_reg == 5'd0)
            nin = 7'd1;
        else if (7'(in_ch_reg) > 7'(MAX_IN_CH))
            nin = 7'(MAX_IN_CH);
        else
            nin = 7'(in_ch_reg);

        if (out_ch_reg == 5'd0)
            nout = 5'd1;
        else if (out_ch_reg > 5'(OUT_HI))
            nout = 5'(OUT_HI);
        else
            nout = out_ch_reg;

        if (taps_reg == 3'd0)
            ntaps = 3'd1;
        else if (5'(taps_reg) > 5'(MAX_TAPS))
            ntaps = 3'(MAX_TAPS);
        else
            ntaps = taps_reg;

        if (dil_reg == 9'd0)
            dil_c = 9'd1;
        else if (dil_reg > 9'd256)
            dil_c = 9'd256;
        else
            dil_c = dil_reg;

        lim = lim_arr[ntaps];
        if (16'(dil_c) > 16'(lim))
            dil = 9'(lim);
        else
            dil = dil_c;

        span_raw = 16'(ntaps - 3'd1) * 16'(dil) + 16'd1;
        if (span_raw > 16'(HIST_DEPTH))
            span = PW'(HIST_DEPTH);
        else
            span = PW'(span_raw);
    end

    // transaction register
    dcc_pkg::op_t       op_reg;
    logic [3:0]         ic_reg;
    logic [3:0]         oc_reg;
    logic [1:0]         tap_reg;
    logic signed [15:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            ic_reg  <= in_channel;
            oc_reg  <= out_channel;
            tap_reg <= tap;
            val_reg <= value;
        end
    end

    // clear sweep
    logic [CLRW-1:0] clr_cnt_reg;
    logic            hist_only_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            hist_only_reg <= 1'b0;
        end
        else if (cmd.clr_init)
        begin
            clr_cnt_reg   <= '0;
            hist_only_reg <= 1'b1;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + CLRW'(1);
        end
    end

    logic clr_done;
    assign clr_done = hist_only_reg ? (clr_cnt_reg == CLRW'(HTOT - 1))
                                    : (clr_cnt_reg == CLRW'(CLR_N - 1));

    // circular pointer
    logic [PTW-1:0] ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cfg_we && (cfg_index == dcc_pkg::REG_KERNEL_TAPS
                            || cfg_index == dcc_pkg::REG_DILATION))
        begin
            ptr_reg <= '0;
        end
        else if (cmd.exec && op_reg == dcc_pkg::OP_CLEAR)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.ptr_adv)
        begin
            if (PW'(ptr_reg) + PW'(1) >= span)
                ptr_reg <= '0;
            else
                ptr_reg <= ptr_reg + PTW'(1);
        end
    end

    // loop counters
    logic [OCW-1:0] o_reg;
    logic [CW-1:0]  c_reg;
    logic [TW-1:0]  t_reg;
    logic [PTW-1:0] pos_reg;
    logic           t_end;
    logic           c_end;
    logic [PW:0]    pos_back;

    assign t_end    = (5'(t_reg) == 5'(ntaps) - 5'd1);
    assign c_end    = (7'(c_reg) == nin - 7'd1);
    assign pos_back = ((PW + 1)'(pos_reg) >= (PW + 1)'(dil))
                      ? (PW + 1)'(pos_reg) - (PW + 1)'(dil)
                      : (PW + 1)'(pos_reg) + (PW + 1)'(span) - (PW + 1)'(dil);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_reg   <= '0;
            c_reg   <= '0;
            t_reg   <= '0;
            pos_reg <= '0;
        end
        else
        begin
            if (cmd.o_init)
                o_reg <= '0;
            else if (cmd.out_load)
                o_reg <= o_reg + OCW'(1);

            if (cmd.o_start)
            begin
                c_reg   <= '0;
                t_reg   <= '0;
                pos_reg <= ptr_reg;
            end
            else if (cmd.mac_issue)
            begin
                if (t_end)
                begin
                    t_reg   <= '0;
                    c_reg   <= c_reg + CW'(1);
                    pos_reg <= ptr_reg;
                end
                else
                begin
                    t_reg   <= t_reg + TW'(1);
                    pos_reg <= PTW'(pos_back);
                end
            end
        end
    end

    // stores
    logic           hist_we;
    logic [HAW-1:0] hist_waddr;
    logic [15:0]    hist_wdata;
    logic [HAW-1:0] hist_raddr;
    logic [15:0]    hist_rdata;
    logic           wt_we;
    logic [WAW-1:0] wt_waddr;
    logic [15:0]    wt_wdata;
    logic [WAW-1:0] wt_raddr;
    logic [15:0]    wt_rdata;
    logic           smp_ok;
    logic           wt_ok;

    assign smp_ok = (7'(ic_reg) < nin);
    assign wt_ok  = (7'(oc_reg) < 7'(MAX_OUT_CH)) && (7'(ic_reg) < 7'(MAX_IN_CH))
                    && (5'(tap_reg) < 5'(MAX_TAPS));

    always_comb
    begin
        if (cmd.clr_step)
        begin
            hist_we    = (32'(clr_cnt_reg) < 32'(HTOT));
            hist_waddr = HAW'(clr_cnt_reg);
            hist_wdata = '0;
            wt_we      = !hist_only_reg && (32'(clr_cnt_reg) < 32'(WTOT));
            wt_waddr   = WAW'(clr_cnt_reg);
            wt_wdata   = '0;
        end
        else
        begin
            hist_we    = cmd.exec && op_reg == dcc_pkg::OP_SAMPLE && smp_ok;
            hist_waddr = HAW'(int'(ic_reg) * HIST_DEPTH + int'(ptr_reg));
            hist_wdata = val_reg;
            wt_we      = cmd.exec && op_reg == dcc_pkg::OP_WEIGHT && wt_ok;
            wt_waddr   = WAW'((int'(oc_reg) * MAX_IN_CH + int'(ic_reg)) * MAX_TAPS
                              + int'(tap_reg));
            wt_wdata   = val_reg;
        end
    end

    assign hist_raddr = HAW'(int'(c_reg) * HIST_DEPTH + int'(pos_reg));
    assign wt_raddr   = WAW'((int'(o_reg) * MAX_IN_CH + int'(c_reg)) * MAX_TAPS
                             + int'(t_reg));

    dcc_ram #(.WIDTH(16), .DEPTH(HTOT)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    dcc_ram #(.WIDTH(16), .DEPTH(WTOT)) u_wt (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    logic signed [15:0] bias_reg [MAX_OUT_CH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_OUT_CH; i++)
            begin
                bias_reg[i] <= '0;
            end
        end
        else if (cmd.exec && op_reg == dcc_pkg::OP_BIAS
                 && 7'(oc_reg) < 7'(MAX_OUT_CH))
        begin
            bias_reg[OCW'(oc_reg)] <= val_reg;
        end
    end

    // MAC pipeline: read, multiply, accumulate
    logic                    v1_reg;
    logic                    v2_reg;
    logic signed [31:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0]      bias_o;

    assign bias_o = bias_reg[o_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= $signed(wt_rdata) * $signed(hist_rdata);
        end
        if (cmd.o_start)
        begin
            acc_reg <= {{(ACC_W - 28){bias_o[15]}}, bias_o, 12'b0};
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // output register
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shr;
    logic signed [15:0]      sat;
    logic                    res_valid_reg;
    logic [3:0]              out_index_reg;
    logic signed [15:0]      out_value_reg;
    logic                    last_reg;
    logic                    o_last;

    assign rnd    = acc_reg + ACC_W'(2048);
    assign shr    = rnd >>> 12;
    assign sat    = (shr > SAT_HI) ? 16'sh7FFF : (shr < SAT_LO) ? 16'sh8000 : 16'(shr);
    assign o_last = (5'(o_reg) == nout - 5'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_index_reg <= 4'(o_reg);
            out_value_reg <= sat;
            last_reg      <= o_last;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

    always_comb
    begin
        sts           = '0;
        sts.op        = op_reg;
        sts.clr_done  = clr_done;
        sts.frame_end = (op_reg == dcc_pkg::OP_SAMPLE) && (7'(ic_reg) == nin - 7'd1);
        sts.mac_last  = t_end && c_end;
        sts.busy      = v1_reg || v2_reg;
        sts.out_free  = !res_valid_reg || res_ready;
        sts.o_last    = o_last;
    end

    a_ptr_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        PW'(ptr_reg) < span)
        else $error("write pointer outside span");

    a_pos_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_issue |-> PW'(pos_reg) < span)
        else $error("tap position outside span");

    a_no_write_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mac_issue || v1_reg) |-> !(hist_we || wt_we))
        else $error("store written during accumulation");

endmodule

FILE: design/dilated_causal_conv1d.sv
// Dilated causal 1D convolution, one shared multiply-accumulate unit.
// s_axis: one transaction per op. tuser = op (0 sample, 1 weight, 2 bias,
//   3 clear history). tdata carries channel, output channel, tap and value.
// cfg: register writes (0 in_channels, 1 out_channels, 2 kernel_taps,
//   3 dilation), always ready; write only while the block is idle.
// m_axis: one transaction per output channel after the sample of the last
//   input channel; tlast marks the final output channel of the frame.
// Weight, bias and non-final sample ops return to idle after executing. A final
//   sample then computes every output channel over in_channels * kernel_taps
//   terms through the single MAC pipeline (history read, multiply, accumulate).
// Reset and clear history run a zeroing sweep over the MAX_IN_CH * HIST_DEPTH
//   history words, one word per cycle (reset also zeroes weights). s_axis is
//   not ready during the sweep.
// A stalled m_axis holds its result in the output register; computation of
//   the next output channel waits for that register to free up.
module dilated_causal_conv1d #(
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_TAPS   = 4,
    parameter int HIST_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // in_channel[3:0] out_channel[7:4] tap[9:8] value[25:10]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_index[3:0] out_value[19:4]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    dcc_pkg::cmd_t      cmd;
    dcc_pkg::sts_t      sts;
    logic [3:0]         out_index;
    logic signed [15:0] out_value;

    assign cfg_ready = 1'b1;

    dcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dcc_dpath #(
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_TAPS   (MAX_TAPS),
        .HIST_DEPTH (HIST_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_op       (dcc_pkg::op_t'(s_axis_tuser)),
        .in_channel  (s_axis_tdata[3:0]),
        .out_channel (s_axis_tdata[7:4]),
        .tap         (s_axis_tdata[9:8]),
        .value       (s_axis_tdata[25:10]),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .out_index   (out_index),
        .out_value   (out_value),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, out_value, out_index};

endmodule
